>>> design/adb_mouse_packet_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// ADB mouse decoder assertion macros
// Shared wrappers for the concurrent checks on the decoder ports.
// ----------------------------------------------------------------------------
`ifndef ADB_MOUSE_PACKET_DECODER_CORE_MACROS_SVH
`define ADB_MOUSE_PACKET_DECODER_CORE_MACROS_SVH

// clocked check, muted while reset is asserted
`define ADBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ADBM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/adbm_pkg.sv
// ----------------------------------------------------------------------------
// ADB mouse decoder package
// Word types, register indexes, constants and helpers shared by the decoder.
// ----------------------------------------------------------------------------
package adbm_pkg;

    typedef enum logic [1:0] {
        REG_CPI           = 2'd0,
        REG_WHEEL_DIV     = 2'd1,
        REG_SCROLL_BUTTON = 2'd2,
        REG_MAX_ACCEL     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        cfg_index_t  index;
        logic [15:0] value;
    } cfg_word_t;

    typedef struct packed {
        logic [2:0] byte_count;
        logic [7:0] data0;
        logic [7:0] data1;
        logic [7:0] data2;
        logic [7:0] data3;
        logic [7:0] data4;
    } pkt_word_t;

    typedef struct packed {
        logic [7:0]        buttons;
        logic signed [7:0] move_x;
        logic signed [7:0] move_y;
        logic signed [7:0] wheel;
    } rpt_word_t;

    // unpacked packet, before scroll masking and acceleration
    typedef struct packed {
        logic        short_pkt;
        logic [7:0]  buttons;
        logic [15:0] ux;
        logic [15:0] uy;
    } decode_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    localparam logic [7:0]         FILL_BASE  = 8'h88;
    localparam logic [7:0]         FILL_YNEG  = 8'h70;
    localparam logic [7:0]         FILL_XNEG  = 8'h07;
    localparam logic [15:0]        CPI_HALVE  = 16'd200;
    localparam logic signed [15:0] MOVE_LIMIT = 16'sd127;

    // divider operand widths: |residue - y| stays below 512
    localparam int DIV_NUM_W = 9;
    localparam int DIV_DEN_W = 8;

    function automatic logic signed [7:0] clamp127(input logic signed [15:0] v);
        logic signed [7:0] r;
        if (v > MOVE_LIMIT)
        begin
            r = 8'(MOVE_LIMIT);
        end
        else if (v < -MOVE_LIMIT)
        begin
            r = 8'(-MOVE_LIMIT);
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

>>> design/adbm_chan_if.sv
// ----------------------------------------------------------------------------
// ADB mouse decoder channel
// Valid/ready channel carrying one word of type T per handshake.
// ----------------------------------------------------------------------------
interface adbm_chan_if #(parameter type T = logic);

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> design/adbm_unpack.sv
// ----------------------------------------------------------------------------
// ADB mouse packet unpacker
// Fills missing bytes with sign-aware pad bytes and splits out buttons and
// the raw 16-bit X/Y deltas.
// ----------------------------------------------------------------------------
module adbm_unpack
    import adbm_pkg::*;
#(
    parameter int PACKET_BYTES = 5
)
(
    input  pkt_word_t word,
    output decode_t   dec
);

    localparam logic [2:0] LEN_MAX = 3'(PACKET_BYTES);

    logic [2:0] len;
    logic [7:0] raw [5];
    logic [7:0] b   [5];
    logic [7:0] last_byte;
    logic       yneg;
    logic       xneg;
    logic [7:0] fill;

    assign raw[0] = word.data0;
    assign raw[1] = word.data1;
    assign raw[2] = word.data2;
    assign raw[3] = word.data3;
    assign raw[4] = word.data4;

    assign len = (word.byte_count > LEN_MAX) ? LEN_MAX : word.byte_count;

    always_comb
    begin
        unique case (len)
            3'd3:    last_byte = raw[2];
            3'd4:    last_byte = raw[3];
            3'd5:    last_byte = raw[4];
            default: last_byte = raw[1];
        endcase
    end

    // two-byte packets carry the signs in bit 6 of each byte
    assign yneg = (len == 3'd2) ? raw[0][6] : last_byte[6];
    assign xneg = (len == 3'd2) ? raw[1][6] : last_byte[2];
    assign fill = FILL_BASE | (yneg ? FILL_YNEG : 8'h00) | (xneg ? FILL_XNEG : 8'h00);

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            b[i] = (3'(i) < len) ? raw[i] : fill;
        end
    end

    assign dec.short_pkt = (len < 3'd2);
    assign dec.buttons   = ~{b[4][3], b[4][7], b[3][3], b[3][7],
                             b[2][3], b[2][7], b[1][7], b[0][7]};
    assign dec.uy        = {b[4][6:4], b[3][6:4], b[2][6:4], b[0][6:0]};
    assign dec.ux        = {b[4][2:0], b[3][2:0], b[2][2:0], b[1][6:0]};

endmodule

>>> design/adbm_div.sv
// ----------------------------------------------------------------------------
// ADB mouse serial divider
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// ----------------------------------------------------------------------------
module adbm_div
    import adbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [DIV_DEN_W-1:0] divisor,
    output div_status_t          status,
    output logic [DIV_NUM_W-1:0] quotient,
    output logic [DIV_DEN_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_NUM_W-1:0] quo_next;
    logic [DIV_DEN_W:0]   rem_reg;
    logic [DIV_DEN_W:0]   rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] den_next;
    logic [DIV_DEN_W:0]   shifted;
    logic                 fits;

    // partial remainder stays below the divisor, so one shift fits
    assign shifted = {rem_reg[DIV_DEN_W-1:0], quo_reg[DIV_NUM_W-1]};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_NUM_W);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (shifted - {1'b0, den_reg}) : shifted;
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg[DIV_DEN_W-1:0];

endmodule

>>> design/adb_mouse_packet_decoder_core.sv
// ----------------------------------------------------------------------------
// ADB mouse packet decoder core
// Turns one polled extended mouse packet into buttons, clamped accelerated
// movement and scroll wheel steps.
// ----------------------------------------------------------------------------
// Usage:
//   cfg : write channel, always ready. index selects resolution (cpi), wheel
//         divider, scroll button or acceleration cap. Write only while idle.
//   pkt : one packet word per poll (byte_count plus five data bytes).
//   rpt : one report word per packet of two or more bytes. A packet of
//         fewer bytes resets the acceleration factor and gives no report.
// Timing: the core takes one packet at a time; pkt.ready is high only while
//   the sequencer is idle. Unscrolled packets go from accept through the
//   two multiply steps (X, then Y), prep and load to a valid report.
//   Scroll packets add the serial divider between prep and load, 9 quotient
//   bits at one per cycle, then its done strobe, before the report is loaded.
//   Short packets finish at accept. The shared 16x8 multiplier does X then Y.
// Stall: the report sits in an output register. If rpt is not taken, the
//   next packet can still be accepted and processed; it then waits in the
//   load state until the output register frees up.
// Reset: config returns to cpi 100, speed 1, no scroll button, cap 8; the
//   acceleration factor goes to 1 and the scroll residue to 0.
// ----------------------------------------------------------------------------
module adb_mouse_packet_decoder_core
    import adbm_pkg::*;
#(
    parameter int PACKET_BYTES = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    adbm_chan_if.sink         cfg,
    adbm_chan_if.sink         pkt,
    adbm_chan_if.source       rpt
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MULX = 6'b000010,
        S_MULY = 6'b000100,
        S_PREP = 6'b001000,
        S_DIV  = 6'b010000,
        S_LOAD = 6'b100000
    } state_t;

    // config registers
    logic [15:0] cpi_reg;
    logic [7:0]  wheel_div_reg;
    logic [3:0]  scroll_button_reg;
    logic [6:0]  max_accel_reg;

    // control
    state_t      state_reg;
    state_t      state_next;
    logic [6:0]  factor_reg;
    logic [6:0]  factor_next;
    logic signed [9:0] residue_reg;
    logic signed [9:0] residue_next;
    logic        rpt_valid_reg;
    logic        rpt_valid_next;

    // per-packet working registers
    logic [7:0]        btn_reg;
    logic              scroll_reg;
    logic [15:0]       ux_reg;
    logic [15:0]       uy_reg;
    logic signed [7:0] mx_reg;
    logic signed [7:0] my_reg;
    logic              st_neg_reg;
    rpt_word_t         rpt_data_reg;
    rpt_word_t         rpt_data_next;

    decode_t           dec;
    logic              pkt_fire;
    logic [7:0]        btn_mask;
    logic [15:0]       mul_a;
    logic signed [23:0] prod;
    logic signed [7:0] mul_clamped;
    logic signed [9:0] st;
    logic [9:0]        st_mag;
    logic [DIV_DEN_W-1:0] divisor;
    logic              div_start;
    div_status_t       div_status;
    logic [DIV_NUM_W-1:0] div_quo;
    logic [DIV_DEN_W-1:0] div_rem;
    logic [6:0]        cap;
    logic              out_free;
    logic [7:0]        wheel_val;

    adbm_unpack #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_unpack (
        .word (pkt.data),
        .dec  (dec)
    );

    adbm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (st_mag[DIV_NUM_W-1:0]),
        .divisor   (divisor),
        .status    (div_status),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign cfg.ready = 1'b1;
    assign pkt.ready = (state_reg == S_IDLE);
    assign pkt_fire  = pkt.valid && pkt.ready;
    assign rpt.valid = rpt_valid_reg;
    assign rpt.data  = rpt_data_reg;
    assign out_free  = !rpt_valid_reg || rpt.ready;

    // scroll buttons above eight select nothing
    assign btn_mask = ((scroll_button_reg != 4'd0) && (scroll_button_reg <= 4'd8))
                    ? (8'h01 << 3'(scroll_button_reg - 4'd1)) : 8'h00;

    // shared multiplier: X in the first step, Y in the second
    assign mul_a       = (state_reg == S_MULX) ? ux_reg : uy_reg;
    assign prod        = $signed(mul_a) * $signed({1'b0, factor_reg});
    assign mul_clamped = clamp127($signed(prod[15:0]));

    // scroll accumulation: residue minus Y, split into sign and magnitude
    assign st       = residue_reg - 10'(my_reg);
    assign st_mag   = st[9] ? (10'd0 - st) : st;
    assign divisor  = (wheel_div_reg == 8'd0) ? 8'd1 : wheel_div_reg;
    assign div_start = (state_reg == S_PREP) && scroll_reg;

    assign cap       = (cpi_reg < CPI_HALVE) ? max_accel_reg : (max_accel_reg >> 1);
    assign wheel_val = 8'(st_neg_reg ? (9'd0 - div_quo) : div_quo);

    always_comb
    begin
        state_next     = state_reg;
        factor_next    = factor_reg;
        residue_next   = residue_reg;
        rpt_valid_next = rpt_valid_reg;
        rpt_data_next  = rpt_data_reg;

        if (rpt_valid_reg && rpt.ready)
        begin
            rpt_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (pkt_fire)
                begin
                    if (dec.short_pkt)
                    begin
                        factor_next = 7'd1;
                    end
                    else
                    begin
                        state_next = S_MULX;
                    end
                end
            end
            S_MULX:
            begin
                state_next = S_MULY;
            end
            S_MULY:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = scroll_reg ? S_DIV : S_LOAD;
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    rpt_valid_next        = 1'b1;
                    rpt_data_next.buttons = btn_reg;
                    if (scroll_reg)
                    begin
                        rpt_data_next.move_x = '0;
                        rpt_data_next.move_y = '0;
                        rpt_data_next.wheel  = $signed(wheel_val);
                        residue_next = st_neg_reg ? (10'sd0 - $signed(10'(div_rem)))
                                                  : $signed(10'(div_rem));
                    end
                    else
                    begin
                        rpt_data_next.move_x = mx_reg;
                        rpt_data_next.move_y = my_reg;
                        rpt_data_next.wheel  = '0;
                        residue_next         = '0;
                    end
                    if (factor_reg < cap)
                    begin
                        factor_next = factor_reg + 7'd1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpi_reg           <= 16'd100;
            wheel_div_reg     <= 8'd1;
            scroll_button_reg <= 4'd0;
            max_accel_reg     <= 7'd8;
            state_reg         <= S_IDLE;
            factor_reg        <= 7'd1;
            residue_reg       <= '0;
            rpt_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.data.index)
                    REG_CPI:           cpi_reg           <= cfg.data.value;
                    REG_WHEEL_DIV:     wheel_div_reg     <= cfg.data.value[7:0];
                    REG_SCROLL_BUTTON: scroll_button_reg <= cfg.data.value[3:0];
                    REG_MAX_ACCEL:     max_accel_reg     <= cfg.data.value[6:0];
                endcase
            end
            state_reg     <= state_next;
            factor_reg    <= factor_next;
            residue_reg   <= residue_next;
            rpt_valid_reg <= rpt_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (pkt_fire)
        begin
            scroll_reg <= (dec.buttons & btn_mask) != 8'h00;
            btn_reg    <= dec.buttons & ~btn_mask;
            ux_reg     <= dec.ux;
            uy_reg     <= dec.uy;
        end
        if (state_reg == S_MULX)
        begin
            mx_reg <= mul_clamped;
        end
        if (state_reg == S_MULY)
        begin
            my_reg <= mul_clamped;
        end
        if (state_reg == S_PREP)
        begin
            st_neg_reg <= st[9];
        end
        rpt_data_reg <= rpt_data_next;
    end

endmodule

>>> design/adbm_checker.sv
// ----------------------------------------------------------------------------
// ADB mouse decoder port checker
// Watches the packet and report channels of the decoder core.
// ----------------------------------------------------------------------------
`include "adb_mouse_packet_decoder_core_macros.svh"

module adbm_checker
    import adbm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      pkt_valid,
    input logic      pkt_ready,
    input logic      rpt_valid,
    input logic      rpt_ready,
    input rpt_word_t rpt_data
);

    logic clamp_ok;

    // movement is clamped to +-127, never the most negative code
    assign clamp_ok = (rpt_data.move_x != 8'sh80) && (rpt_data.move_y != 8'sh80);

    // report held under backpressure
    `ADBM_ASSERT(a_rpt_hold, rpt_valid && !rpt_ready |=> rpt_valid, "report dropped")
    `ADBM_ASSERT(a_rpt_stable, rpt_valid && !rpt_ready |=> $stable(rpt_data), "report moved")

    `ADBM_ASSERT(a_move_clamp, rpt_valid |-> clamp_ok, "movement outside clamp range")

    // reports are loaded only from the load state, so no new report right after accept
    `ADBM_ASSERT(a_no_fast_rpt, pkt_valid && pkt_ready |=> !$rose(rpt_valid), "report too soon")

    `ADBM_ASSERT_RST(a_rst_quiet, !rst_n |=> !rpt_valid, "report valid during reset")

endmodule

bind adb_mouse_packet_decoder_core adbm_checker u_adbm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_valid (pkt.valid),
    .pkt_ready (pkt.ready),
    .rpt_valid (rpt.valid),
    .rpt_ready (rpt.ready),
    .rpt_data  (rpt.data)
);

>>> tb/adb_mouse_packet_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// ADB mouse packet decoder testbench
// Drives polled packet words into the decoder core and checks every report
// word against a cycle-free predictor of buttons, acceleration, clamping and
// scroll stepping. A short table of hand-picked packets and register writes
// comes first, then random traffic over several register settings, with
// bursty packet input and a report sink that stalls in changing patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module adb_mouse_packet_decoder_core_tb;
    import adbm_pkg::*;

    localparam int PKT_BYTES       = 5;
    localparam int SETTLE_CYCLES   = 24;   // covers the scroll divider path
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 230;

    // kinds of rows in the directed table
    typedef enum logic [1:0] {
        ROW_NONE,     // packet, no report may come
        ROW_REPORT,   // packet, report typed into the row
        ROW_PREDICT,  // packet, report from the predictor
        ROW_REG       // register write
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        cfg_index_t idx;
        logic [15:0] val;
        pkt_word_t  pkt;
        rpt_word_t  want;
    } stim_row_t;

    typedef struct packed {
        logic [15:0] cpi;
        logic [7:0]  speed;
        logic [3:0]  button;
        logic [6:0]  cap;
    } phase_cfg_t;

    // Packet bytes read data0..data4 left to right; report reads
    // buttons, move_x, move_y, wheel. Typed rows start with factor 1
    // (a short packet just before) or have zero movement.
    localparam stim_row_t DIRECTED_ROWS [0:26] = '{
        '{ROW_NONE,    REG_CPI,           16'd0,  {3'd0, 40'h00_00_00_00_00}, 32'h0},
        // two bytes: garbage upper bytes must be replaced by released fill
        '{ROW_REPORT,  REG_CPI,           16'd0,  {3'd2, 40'h80_80_00_00_00}, 32'h00_00_00_00},
        '{ROW_REPORT,  REG_CPI,           16'd0,  {3'd2, 40'h00_00_00_00_00}, 32'h03_00_00_00},
        '{ROW_NONE,    REG_CPI,           16'd0,  {3'd1, 40'h00_00_00_00_00}, 32'h0},
        '{ROW_REPORT,  REG_CPI,           16'd0,  {3'd5, 40'h00_00_00_00_00}, 32'hFF_00_00_00},
        '{ROW_NONE,    REG_CPI,           16'd0,  {3'd0, 40'h00_00_00_00_00}, 32'h0},
        // largest positive X, clamps to +127
        '{ROW_REPORT,  REG_CPI,           16'd0,  {3'd5, 40'h80_FF_8F_8F_8B}, 32'h00_7F_00_00},
        '{ROW_NONE,    REG_CPI,           16'd0,  {3'd0, 40'h00_00_00_00_00}, 32'h0},
        // most negative X, clamps to -127
        '{ROW_REPORT,  REG_CPI,           16'd0,  {3'd5, 40'h80_80_88_88_8C}, 32'h00_81_00_00},
        '{ROW_NONE,    REG_CPI,           16'd0,  {3'd0, 40'h00_00_00_00_00}, 32'h0},
        '{ROW_REPORT,  REG_CPI,           16'd0,  {3'd5, 40'hFF_80_F8_F8_B8}, 32'h00_00_7F_00},
        '{ROW_NONE,    REG_CPI,           16'd0,  {3'd0, 40'h00_00_00_00_00}, 32'h0},
        '{ROW_REPORT,  REG_CPI,           16'd0,  {3'd5, 40'h80_80_88_88_C8}, 32'h00_00_81_00},
        '{ROW_NONE,    REG_CPI,           16'd0,  {3'd0, 40'h00_00_00_00_00}, 32'h0},
        // two bytes, both signs negative: fill is 0xFF
        '{ROW_REPORT,  REG_CPI,           16'd0,  {3'd2, 40'hC0_FF_00_00_00}, 32'h00_FF_C0_00},
        // count above five saturates
        '{ROW_REPORT,  REG_CPI,           16'd0,  {3'd7, 40'h00_00_00_00_00}, 32'hFF_00_00_00},
        '{ROW_PREDICT, REG_CPI,           16'd0,  {3'd3, 40'h12_34_C4_00_00}, 32'h0},
        '{ROW_PREDICT, REG_CPI,           16'd0,  {3'd4, 40'h05_7A_3B_49_00}, 32'h0},
        // scroll on button 2, three counts per step
        '{ROW_REG,     REG_SCROLL_BUTTON, 16'd2,  '0,                         32'h0},
        '{ROW_REG,     REG_WHEEL_DIV,     16'd3,  '0,                         32'h0},
        '{ROW_PREDICT, REG_CPI,           16'd0,  {3'd2, 40'h10_00_00_00_00}, 32'h0},
        '{ROW_PREDICT, REG_CPI,           16'd0,  {3'd3, 40'h75_00_F7_00_00}, 32'h0},
        // button number above eight never scrolls
        '{ROW_REG,     REG_SCROLL_BUTTON, 16'd12, '0,                         32'h0},
        '{ROW_PREDICT, REG_CPI,           16'd0,  {3'd2, 40'h00_00_00_00_00}, 32'h0},
        // speed zero acts as one
        '{ROW_REG,     REG_WHEEL_DIV,     16'd0,  '0,                         32'h0},
        '{ROW_REG,     REG_SCROLL_BUTTON, 16'd1,  '0,                         32'h0},
        '{ROW_PREDICT, REG_CPI,           16'd0,  {3'd4, 40'h3C_80_F8_88_00}, 32'h0}
    };

    // extremes first; later phases pick their settings at random
    localparam phase_cfg_t FIXED_PHASES [0:3] = '{
        '{16'd0,     8'd255, 4'd8,  7'd127},
        '{16'hFFFF,  8'd1,   4'd1,  7'd1},
        '{16'd199,   8'd0,   4'd15, 7'd0},
        '{16'd200,   8'd7,   4'd3,  7'd126}
    };

    logic clk;
    logic rst_n;

    adbm_chan_if #(.T(cfg_word_t)) cfg_ch ();
    adbm_chan_if #(.T(pkt_word_t)) pkt_ch ();
    adbm_chan_if #(.T(rpt_word_t)) rpt_ch ();

    adb_mouse_packet_decoder_core #(
        .PACKET_BYTES (PKT_BYTES)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .pkt   (pkt_ch),
        .rpt   (rpt_ch)
    );

    // predictor copy of the registers and the decoder state
    logic [15:0] cpi_cfg;
    logic [7:0]  speed_cfg;
    logic [3:0]  scroll_btn_cfg;
    logic [6:0]  accel_cap_cfg;
    logic [6:0]  accel_factor;
    int          scroll_residue;

    rpt_word_t pending_reports [$];
    int        mismatches = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the core hangs
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // multiply by the factor, wrap to 16 bits, clamp to +-127
    function automatic logic signed [7:0] accelerate_axis(input logic [15:0] raw,
                                                          input logic [6:0] factor);
        int                 prod;
        logic signed [15:0] wrapped;
        logic signed [7:0]  lim;
        prod    = int'($signed(raw)) * int'(factor);
        wrapped = prod[15:0];
        if (wrapped > 16'sd127)
        begin
            lim = 8'sd127;
        end
        else if (wrapped < -16'sd127)
        begin
            lim = -8'sd127;
        end
        else
        begin
            lim = wrapped[7:0];
        end
        return lim;
    endfunction

    // Works out the report word of one accepted packet and advances the
    // predictor state. Returns 0 when the packet gives no report.
    function automatic bit expected_report(input pkt_word_t w, output rpt_word_t r);
        logic [7:0]        b [PKT_BYTES];
        int                n;
        bit                xneg;
        bit                yneg;
        bit                scroll;
        logic [7:0]        held;
        logic [7:0]        mask;
        logic [15:0]       ux;
        logic [15:0]       uy;
        logic signed [7:0] mx;
        logic signed [7:0] my;
        int                sp;
        int                acc;
        int                steps;
        logic [6:0]        cap;

        r    = '0;
        b[0] = w.data0;
        b[1] = w.data1;
        b[2] = w.data2;
        b[3] = w.data3;
        b[4] = w.data4;
        n    = (w.byte_count > PKT_BYTES) ? PKT_BYTES : int'(w.byte_count);

        if (n < 2)
        begin
            accel_factor = 7'd1;
            return 1'b0;
        end

        // sign of the missing bytes
        if (n == 2)
        begin
            yneg = b[0][6];
            xneg = b[1][6];
        end
        else
        begin
            yneg = b[n-1][6];
            xneg = b[n-1][2];
        end
        for (int i = n; i < PKT_BYTES; i++)
        begin
            b[i] = FILL_BASE | (yneg ? FILL_YNEG : 8'h00) | (xneg ? FILL_XNEG : 8'h00);
        end

        // buttons are active low
        held = ~{b[4][3], b[4][7], b[3][3], b[3][7], b[2][3], b[2][7], b[1][7], b[0][7]};
        mask = (scroll_btn_cfg >= 4'd1 && scroll_btn_cfg <= 4'd8) ?
               8'(1 << (scroll_btn_cfg - 4'd1)) : 8'h00;
        scroll = (held & mask) != 8'h00;
        held   = held & ~mask;

        uy = {b[4][6:4], b[3][6:4], b[2][6:4], b[0][6:0]};
        ux = {b[4][2:0], b[3][2:0], b[2][2:0], b[1][6:0]};
        mx = accelerate_axis(ux, accel_factor);
        my = accelerate_axis(uy, accel_factor);

        if (scroll)
        begin
            sp             = (speed_cfg == 8'd0) ? 1 : int'(speed_cfg);
            acc            = scroll_residue - int'(my);
            steps          = acc / sp;
            scroll_residue = acc % sp;
            mx             = '0;
            my             = '0;
        end
        else
        begin
            scroll_residue = 0;
            steps          = 0;
        end

        r.buttons = held;
        r.move_x  = mx;
        r.move_y  = my;
        r.wheel   = steps[7:0];

        cap = (cpi_cfg < CPI_HALVE) ? accel_cap_cfg : (accel_cap_cfg >> 1);
        if (accel_factor < cap)
        begin
            accel_factor = accel_factor + 7'd1;
        end
        return 1'b1;
    endfunction

    function automatic logic [15:0] random_delta();
        logic [15:0] d;
        case ($urandom_range(0, 3))
            0:       d = 16'($urandom_range(0, 6)) - 16'd3;
            1:       d = 16'($urandom_range(0, 48)) - 16'd24;
            2:       d = 16'($urandom_range(0, 800)) - 16'd400;
            default: d = 16'($urandom);
        endcase
        return d;
    endfunction

    // Mostly well-formed packets built from button and delta values, the
    // rest short polls and raw noise (which also covers counts six and seven).
    function automatic pkt_word_t random_packet();
        pkt_word_t   w;
        int          pick;
        logic [7:0]  down;
        logic [15:0] dx;
        logic [15:0] dy;

        w    = 43'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            w.byte_count = 3'($urandom_range(0, 1));
        end
        else if (pick >= 14)
        begin
            down = 8'($urandom);
            // hold the scroll button most of the time so the residue builds up
            if (scroll_btn_cfg >= 4'd1 && scroll_btn_cfg <= 4'd8 && $urandom_range(0, 3) != 0)
            begin
                down[scroll_btn_cfg - 4'd1] = 1'b1;
            end
            dx           = random_delta();
            dy           = random_delta();
            w.byte_count = 3'($urandom_range(2, 5));
            w.data0      = {~down[0], dy[6:0]};
            w.data1      = {~down[1], dx[6:0]};
            w.data2      = {~down[2], dy[9:7],   ~down[3], dx[9:7]};
            w.data3      = {~down[4], dy[12:10], ~down[5], dx[12:10]};
            w.data4      = {~down[6], dy[15:13], ~down[7], dx[15:13]};
        end
        return w;
    endfunction

    task automatic send_packet(input pkt_word_t w);
        @(negedge clk);
        pkt_ch.valid <= 1'b1;
        pkt_ch.data  <= w;
        do @(posedge clk); while (!pkt_ch.ready);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{idx, val};
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_CPI:           cpi_cfg        = val;
            REG_WHEEL_DIV:     speed_cfg      = val[7:0];
            REG_SCROLL_BUTTON: scroll_btn_cfg = val[3:0];
            REG_MAX_ACCEL:     accel_cap_cfg  = val[6:0];
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // stop sending, let every report come out, then wait out the settle
    // time before going on
    task automatic drain_pending();
        @(negedge clk);
        pkt_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // report sink: ready pattern switches between always, coin flip,
    // mostly stalled and alternating
    initial
    begin
        int stall_mode;
        int stall_left;
        stall_mode   = 0;
        stall_left   = 0;
        rpt_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(8, 80);
            end
            else
            begin
                stall_left--;
            end
            case (stall_mode)
                0:       rpt_ch.ready <= 1'b1;
                1:       rpt_ch.ready <= 1'($urandom_range(0, 1));
                2:       rpt_ch.ready <= ($urandom_range(0, 5) == 0);
                default: rpt_ch.ready <= stall_left[0];
            endcase
        end
    end

    // every report word taken is checked against the oldest expectation
    always @(posedge clk)
    begin
        rpt_word_t got;
        rpt_word_t want;
        if (rst_n && rpt_ch.valid && rpt_ch.ready)
        begin
            got = rpt_ch.data;
            if (pending_reports.size() == 0)
            begin
                $display("%0t ns: report word, expected none, got %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("buttons", want.buttons, got.buttons);
                check_field("move_x",  want.move_x,  got.move_x);
                check_field("move_y",  want.move_y,  got.move_y);
                check_field("wheel",   want.wheel,   got.wheel);
            end
        end
    end

    initial
    begin
        stim_row_t  row;
        rpt_word_t  r;
        bit         made;
        phase_cfg_t set;
        pkt_word_t  w;
        int         burst;

        rst_n        = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        pkt_ch.valid = 1'b0;
        pkt_ch.data  = '0;

        cpi_cfg        = 16'd100;
        speed_cfg      = 8'd1;
        scroll_btn_cfg = 4'd0;
        accel_cap_cfg  = 7'd8;
        accel_factor   = 7'd1;
        scroll_residue = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table, reset register values until the first write row
        foreach (DIRECTED_ROWS[i])
        begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_REG)
            begin
                drain_pending();
                write_reg(row.idx, row.val);
            end
            else
            begin
                send_packet(row.pkt);
                made = expected_report(row.pkt, r);
                if (row.kind == ROW_REPORT)
                begin
                    pending_reports.push_back(row.want);
                end
                else if (row.kind == ROW_PREDICT && made)
                begin
                    pending_reports.push_back(r);
                end
            end
        end

        // random traffic, one register setting per phase
        burst = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph < 4)
            begin
                set = FIXED_PHASES[ph];
            end
            else
            begin
                set.cpi    = ($urandom_range(0, 1) == 0) ? 16'($urandom) :
                             16'($urandom_range(150, 250));
                set.speed  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                             8'($urandom_range(1, 9));
                set.button = 4'($urandom_range(0, 9));
                set.cap    = 7'($urandom_range(0, 127));
            end
            drain_pending();
            write_reg(REG_CPI,           set.cpi);
            write_reg(REG_WHEEL_DIV,     16'(set.speed));
            write_reg(REG_SCROLL_BUTTON, 16'(set.button));
            write_reg(REG_MAX_ACCEL,     16'(set.cap));

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (burst == 0)
                begin
                    // now and then hold off until the core has emptied out
                    if ($urandom_range(0, 39) == 0)
                    begin
                        drain_pending();
                    end
                    else
                    begin
                        @(negedge clk);
                        pkt_ch.valid <= 1'b0;
                        repeat ($urandom_range(0, 7)) @(negedge clk);
                    end
                    burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) :
                            $urandom_range(1, 12);
                end
                w = random_packet();
                send_packet(w);
                if (expected_report(w, r))
                begin
                    pending_reports.push_back(r);
                end
                burst--;
            end
        end

        drain_pending();
        repeat (30) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/adbm_pkg.sv
design/adbm_chan_if.sv
design/adbm_unpack.sv
design/adbm_div.sv
design/adb_mouse_packet_decoder_core.sv
design/adbm_checker.sv
tb/adb_mouse_packet_decoder_core_tb.sv
